// ===== rtl/assert_macros.svh =====
// assertion macros shared by the pid delta unit modules
// expects clk and rst_n (async, active low) in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PIDPD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PIDPD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pidpd_pkg.sv =====
// types, widths and codes of the pid position/delta unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pidpd_pkg;

    // sample and gain format
    localparam int DATA_WIDTH     = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int GAIN_W         = 16;
    localparam int LIMIT_W        = DATA_WIDTH - 1;

    // error and operand widths
    localparam int ERR_W = DATA_WIDTH + 1;
    localparam int OPP_W = ERR_W + 1;
    localparam int OPD_W = ERR_W + 2;

    // product widths and rounded term widths
    localparam int PROD_P_W = GAIN_W + OPP_W;
    localparam int PROD_I_W = GAIN_W + ERR_W;
    localparam int PROD_D_W = GAIN_W + OPD_W;
    localparam int TERM_P_W = PROD_P_W - GAIN_FRAC_BITS;
    localparam int TERM_I_W = PROD_I_W - GAIN_FRAC_BITS;
    localparam int TERM_D_W = PROD_D_W - GAIN_FRAC_BITS;
    localparam int SUM_W    = TERM_D_W + 3;
    localparam int ROUND_HALF = (GAIN_FRAC_BITS > 0) ? (1 << (GAIN_FRAC_BITS - 1)) : 0;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE_SELECT    = 3'd0,
        CFG_GAIN_P         = 3'd1,
        CFG_GAIN_I         = 3'd2,
        CFG_GAIN_D         = 3'd3,
        CFG_OUTPUT_LIMIT   = 3'd4,
        CFG_INTEGRAL_BOUND = 3'd5,
        CFG_ERROR_CEILING  = 3'd6,
        CFG_DEAD_ZONE      = 3'd7
    } pidpd_cfg_index_t;

    typedef enum logic [1:0] {
        SUP_NONE     = 2'd0,
        SUP_CEILING  = 2'd1,
        SUP_DEADZONE = 2'd2
    } pidpd_sup_t;

    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    typedef struct packed {
        logic                      mode_select;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic [LIMIT_W-1:0]        output_limit;
        logic [LIMIT_W-1:0]        integral_bound;
        logic [DATA_WIDTH-1:0]     error_ceiling;
        logic [DATA_WIDTH-1:0]     dead_zone;
    } pidpd_cfg_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] measured;
        logic signed [DATA_WIDTH-1:0] setpoint;
    } pidpd_sample_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] drive;
        pidpd_sup_t                   suppressed;
    } pidpd_result_t;

    // classified sample handed from front to back
    typedef struct packed {
        pidpd_sup_t              sup;
        logic signed [OPP_W-1:0] op_p;
        logic signed [ERR_W-1:0] op_i;
        logic signed [OPD_W-1:0] op_d;
    } pidpd_job_t;

    // symmetric clamp of a wide sum to +-bound
    function automatic logic signed [DATA_WIDTH-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] value,
        input logic [LIMIT_W-1:0]      bound
    );
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(signed'({1'b0, bound}));
        lo = -hi;
        if (value > hi)
        begin
            return hi[DATA_WIDTH-1:0];
        end
        else if (value < lo)
        begin
            return lo[DATA_WIDTH-1:0];
        end
        return value[DATA_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/pidpd_front.sv =====
// front end: forms the error, classifies suppression, keeps error history
// depends on pidpd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pidpd_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pidpd_pkg::pidpd_cfg_t  cfg,
    input  logic                   sample_valid,
    input  pidpd_pkg::pidpd_sample_t sample,
    output logic                   sample_ready,
    input  logic                   q_full,
    output logic                   push,
    output pidpd_pkg::pidpd_job_t  push_job
);
    import pidpd_pkg::*;

    logic signed [ERR_W-1:0] err_prev_reg;
    logic signed [ERR_W-1:0] err_prev_next;
    logic signed [ERR_W-1:0] err_prev2_reg;
    logic signed [ERR_W-1:0] err_prev2_next;
    logic signed [ERR_W-1:0] err;
    logic [ERR_W-1:0]        mag;
    logic signed [OPP_W-1:0] diff1;
    logic signed [OPD_W-1:0] diff2;
    pidpd_sup_t              sup_code;
    logic                    sample_accept;

    // error and its magnitude
    assign err = ERR_W'(sample.setpoint) - ERR_W'(sample.measured);
    assign mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

    // ceiling is checked before the dead zone
    always_comb
    begin
        priority if ((cfg.error_ceiling != '0) && (mag > ERR_W'(cfg.error_ceiling)))
        begin
            sup_code = SUP_CEILING;
        end
        else if ((cfg.dead_zone != '0) && (mag < ERR_W'(cfg.dead_zone)))
        begin
            sup_code = SUP_DEADZONE;
        end
        else
        begin
            sup_code = SUP_NONE;
        end
    end

    // first and second differences against history
    assign diff1 = OPP_W'(err) - OPP_W'(err_prev_reg);
    assign diff2 = OPD_W'(err) - (OPD_W'(err_prev_reg) <<< 1) + OPD_W'(err_prev2_reg);

    // multiplier operands chosen by mode
    always_comb
    begin
        push_job.sup  = sup_code;
        push_job.op_i = err;
        if (cfg.mode_select == MODE_INCREMENTAL)
        begin
            push_job.op_p = diff1;
            push_job.op_d = diff2;
        end
        else
        begin
            push_job.op_p = OPP_W'(err);
            push_job.op_d = OPD_W'(diff1);
        end
    end

    // handshake into the queue
    assign sample_ready  = !q_full;
    assign sample_accept = sample_valid && sample_ready;
    assign push          = sample_accept;

    // history moves only on computed samples
    always_comb
    begin
        err_prev_next  = err_prev_reg;
        err_prev2_next = err_prev2_reg;
        if (sample_accept && (sup_code == SUP_NONE))
        begin
            err_prev_next  = err;
            err_prev2_next = err_prev_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_prev_reg  <= '0;
            err_prev2_reg <= '0;
        end
        else
        begin
            err_prev_reg  <= err_prev_next;
            err_prev2_reg <= err_prev2_next;
        end
    end

    `PIDPD_ASSERT_NXT(a_hist_hold_on_suppress,
        sample_accept && (sup_code != SUP_NONE),
        $stable(err_prev_reg) && $stable(err_prev2_reg),
        "error history changed on a suppressed request")

endmodule

// ===== rtl/pidpd_queue.sv =====
// short queue of classified samples between front and back
// depends on pidpd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pidpd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pidpd_pkg::pidpd_job_t push_job,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output pidpd_pkg::pidpd_job_t pop_job
);
    import pidpd_pkg::*;

    pidpd_job_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_job   = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    `PIDPD_ASSERT_IMP(a_q_no_underflow, pop, count_reg != '0,
        "queue popped while empty")
    `PIDPD_ASSERT_IMP(a_q_no_overflow, push && !pop,
        count_reg != QCNT_W'(QUEUE_DEPTH), "queue pushed while full")

endmodule

// ===== rtl/pidpd_back.sv =====
// back end: gain products, integral and drive accumulation, result register
// depends on pidpd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pidpd_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pidpd_pkg::pidpd_cfg_t    cfg,
    input  logic                     job_valid,
    input  pidpd_pkg::pidpd_job_t    job,
    output logic                     job_pop,
    output logic                     result_valid,
    input  logic                     result_ready,
    output pidpd_pkg::pidpd_result_t result
);
    import pidpd_pkg::*;

    // product stage
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    pidpd_sup_t                  s1_sup_reg;
    logic signed [TERM_P_W-1:0]  term_p_reg;
    logic signed [TERM_I_W-1:0]  term_i_reg;
    logic signed [TERM_D_W-1:0]  term_d_reg;
    logic signed [PROD_P_W-1:0]  prod_p;
    logic signed [PROD_I_W-1:0]  prod_i;
    logic signed [PROD_D_W-1:0]  prod_d;
    logic signed [PROD_P_W-1:0]  rnd_p;
    logic signed [PROD_I_W-1:0]  rnd_i;
    logic signed [PROD_D_W-1:0]  rnd_d;

    // accumulation stage and state
    logic                          result_valid_reg;
    logic                          result_valid_next;
    pidpd_result_t                 result_reg;
    pidpd_result_t                 result_next;
    logic signed [DATA_WIDTH-1:0]  integral_sum_reg;
    logic signed [DATA_WIDTH-1:0]  integral_sum_next;
    logic signed [DATA_WIDTH-1:0]  prev_drive_reg;
    logic signed [DATA_WIDTH-1:0]  prev_drive_next;
    logic signed [SUM_W-1:0]       integ_raw;
    logic signed [DATA_WIDTH-1:0]  integ_new;
    logic signed [SUM_W-1:0]       drive_raw;
    logic signed [DATA_WIDTH-1:0]  drive_new;

    logic out_adv;
    logic s1_adv;
    logic s1_open;

    // pipeline flow control
    assign out_adv = !result_valid_reg || result_ready;
    assign s1_adv  = s1_valid_reg && out_adv;
    assign s1_open = !s1_valid_reg || out_adv;
    assign job_pop = job_valid && s1_open;

    assign s1_valid_next     = s1_open ? job_valid : s1_valid_reg;
    assign result_valid_next = out_adv ? s1_valid_reg : result_valid_reg;

    // gain products with round half up
    assign prod_p = cfg.gain_p * job.op_p;
    assign prod_i = cfg.gain_i * job.op_i;
    assign prod_d = cfg.gain_d * job.op_d;
    assign rnd_p  = prod_p + PROD_P_W'(ROUND_HALF);
    assign rnd_i  = prod_i + PROD_I_W'(ROUND_HALF);
    assign rnd_d  = prod_d + PROD_D_W'(ROUND_HALF);

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            s1_sup_reg <= job.sup;
            term_p_reg <= rnd_p[PROD_P_W-1:GAIN_FRAC_BITS];
            term_i_reg <= rnd_i[PROD_I_W-1:GAIN_FRAC_BITS];
            term_d_reg <= rnd_d[PROD_D_W-1:GAIN_FRAC_BITS];
        end
    end

    // integral and drive sums, mode picks the running bases
    always_comb
    begin
        if (cfg.mode_select == MODE_INCREMENTAL)
        begin
            integ_raw = SUM_W'(term_i_reg);
        end
        else
        begin
            integ_raw = SUM_W'(integral_sum_reg) + SUM_W'(term_i_reg);
        end
        integ_new = clamp_sym(integ_raw, cfg.integral_bound);
        drive_raw = SUM_W'(term_p_reg) + SUM_W'(integ_new) + SUM_W'(term_d_reg);
        if (cfg.mode_select == MODE_INCREMENTAL)
        begin
            drive_raw = drive_raw + SUM_W'(prev_drive_reg);
        end
        drive_new = clamp_sym(drive_raw, cfg.output_limit);
    end

    // result and state update
    always_comb
    begin
        result_next       = result_reg;
        integral_sum_next = integral_sum_reg;
        prev_drive_next   = prev_drive_reg;
        if (s1_adv)
        begin
            result_next.suppressed = s1_sup_reg;
            if (s1_sup_reg == SUP_NONE)
            begin
                result_next.drive = drive_new;
                integral_sum_next = integ_new;
                if (cfg.mode_select == MODE_INCREMENTAL)
                begin
                    prev_drive_next = drive_new;
                end
            end
            else
            begin
                result_next.drive = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            integral_sum_reg <= '0;
            prev_drive_reg   <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            integral_sum_reg <= integral_sum_next;
            prev_drive_reg   <= prev_drive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `PIDPD_ASSERT_IMP(a_suppressed_drive_zero,
        result_valid_reg && (result_reg.suppressed != SUP_NONE),
        result_reg.drive == '0, "suppressed result carries a nonzero drive")
    `PIDPD_ASSERT_NXT(a_positional_keeps_prev_drive,
        s1_adv && (cfg.mode_select == MODE_POSITIONAL),
        $stable(prev_drive_reg), "previous drive changed in positional mode")

endmodule

// ===== rtl/pid_controller_position_delta_unit.sv =====
// top level of the pid position/delta unit: register file, front, queue, back
// depends on pidpd_pkg, pidpd_front, pidpd_queue, pidpd_back
//
//  port group       | handshake                   | contents
//  -----------------+-----------------------------+------------------------------
//  sample           | sample_valid / sample_ready | measured, setpoint
//  result           | result_valid / result_ready | drive, suppressed
//  cfg              | cfg_we (no wait)            | cfg_index, cfg_data
//
// one request per cycle sustained while result_ready is high; a request is
// registered in the queue slot at its accepting edge, then in the product stage
// (three gain multipliers), then the accumulate stage; async active-low reset
// clears history, integral, previous drive and valid flags and sets registers
// to defaults; a stalled result holds the back end; the two-slot queue keeps
// the front taking requests until it fills, then sample_ready drops
`timescale 1ns / 1ps

module pid_controller_position_delta_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pidpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pidpd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  pidpd_pkg::pidpd_sample_t            sample,
    output logic                                result_valid,
    input  logic                                result_ready,
    output pidpd_pkg::pidpd_result_t            result
);
    import pidpd_pkg::*;

    pidpd_cfg_t cfg_reg;
    pidpd_cfg_t cfg_next;
    logic       push;
    pidpd_job_t push_job;
    logic       q_full;
    logic       pop;
    logic       q_not_empty;
    pidpd_job_t pop_job;

    // register writes, values masked to register widths
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (pidpd_cfg_index_t'(cfg_index))
                CFG_MODE_SELECT:    cfg_next.mode_select    = cfg_data[0];
                CFG_GAIN_P:         cfg_next.gain_p         = cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:         cfg_next.gain_i         = cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:         cfg_next.gain_d         = cfg_data[GAIN_W-1:0];
                CFG_OUTPUT_LIMIT:   cfg_next.output_limit   = cfg_data[LIMIT_W-1:0];
                CFG_INTEGRAL_BOUND: cfg_next.integral_bound = cfg_data[LIMIT_W-1:0];
                CFG_ERROR_CEILING:  cfg_next.error_ceiling  = cfg_data[DATA_WIDTH-1:0];
                CFG_DEAD_ZONE:      cfg_next.dead_zone      = cfg_data[DATA_WIDTH-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_select    <= MODE_POSITIONAL;
            cfg_reg.gain_p         <= '0;
            cfg_reg.gain_i         <= '0;
            cfg_reg.gain_d         <= '0;
            cfg_reg.output_limit   <= '1;
            cfg_reg.integral_bound <= '1;
            cfg_reg.error_ceiling  <= '0;
            cfg_reg.dead_zone      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // classify and track error history
    pidpd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (sample_valid),
        .sample       (sample),
        .sample_ready (sample_ready),
        .q_full       (q_full),
        .push         (push),
        .push_job     (push_job)
    );

    // decoupling queue
    pidpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_job   (pop_job)
    );

    // products, accumulation, result register
    pidpd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .job_valid    (q_not_empty),
        .job          (pop_job),
        .job_pop      (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== test/pidpd_checker.sv =====
// result checker for the pid position/delta unit: tracks register writes,
// predicts each drive from the accepted requests and compares in order
// depends on pidpd_pkg
`timescale 1ns / 1ps

module pidpd_checker
    import pidpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   sample_valid,
    input  logic                   sample_ready,
    input  pidpd_sample_t          sample,
    input  logic                   result_valid,
    input  logic                   result_ready,
    input  pidpd_result_t          result,
    output int                     fail_count,
    output int                     backlog,
    output int                     checked_count
);

    // register copy, at reset values
    logic   ctrl_mode   = MODE_POSITIONAL;
    longint kp          = 0;
    longint ki          = 0;
    longint kd          = 0;
    longint drive_lim   = 32767;
    longint integ_lim   = 32767;
    longint err_ceiling = 0;
    longint err_floor   = 0;

    // controller history
    longint err_last   = 0;
    longint err_last2  = 0;
    longint integ_acc  = 0;
    longint last_drive = 0;

    pidpd_result_t expected_drives[$];
    int            mismatches = 0;
    int            checked    = 0;

    // product of a q8.8 gain to integer, round half up (arithmetic shift is floor)
    function automatic longint round_gain(input longint prod);
        return (prod + ROUND_HALF) >>> GAIN_FRAC_BITS;
    endfunction

    function automatic longint clamp_to(input longint value, input longint bound);
        if (value > bound)
            return bound;
        if (value < -bound)
            return -bound;
        return value;
    endfunction

    // next drive for one request; updates history unless suppressed
    function automatic pidpd_result_t predict_drive(input pidpd_sample_t s);
        pidpd_result_t r;
        longint        e;
        longint        mag;
        longint        p_term;
        longint        d_term;
        longint        total;
        e = longint'($signed(s.setpoint)) - longint'($signed(s.measured));
        mag = (e < 0) ? -e : e;
        r.drive = '0;
        r.suppressed = SUP_NONE;
        // ceiling wins over dead zone when both apply
        if (err_ceiling != 0 && mag > err_ceiling)
        begin
            r.suppressed = SUP_CEILING;
            return r;
        end
        if (err_floor != 0 && mag < err_floor)
        begin
            r.suppressed = SUP_DEADZONE;
            return r;
        end
        if (ctrl_mode == MODE_POSITIONAL)
        begin
            p_term = round_gain(kp * e);
            d_term = round_gain(kd * (e - err_last));
            integ_acc = clamp_to(integ_acc + round_gain(ki * e), integ_lim);
            total = clamp_to(p_term + integ_acc + d_term, drive_lim);
        end
        else
        begin
            p_term = round_gain(kp * (e - err_last));
            d_term = round_gain(kd * (e - 2 * err_last + err_last2));
            integ_acc = clamp_to(round_gain(ki * e), integ_lim);
            total = clamp_to(last_drive + p_term + integ_acc + d_term, drive_lim);
            last_drive = total;
        end
        err_last2 = err_last;
        err_last = e;
        r.drive = total[DATA_WIDTH-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pidpd_result_t want;
        if (!rst_n)
        begin
            ctrl_mode = MODE_POSITIONAL;
            kp = 0;
            ki = 0;
            kd = 0;
            drive_lim = 32767;
            integ_lim = 32767;
            err_ceiling = 0;
            err_floor = 0;
            err_last = 0;
            err_last2 = 0;
            integ_acc = 0;
            last_drive = 0;
            expected_drives.delete();
        end
        else
        begin
            // compare an accepted result with the oldest prediction
            if (result_valid && result_ready)
            begin
                if (expected_drives.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, actual drive %0d code %0d",
                             $time, result.drive, result.suppressed);
                end
                else
                begin
                    want = expected_drives.pop_front();
                    checked++;
                    if (result.drive !== want.drive)
                    begin
                        mismatches++;
                        $display("%0t: drive mismatch: expected %0d, actual %0d",
                                 $time, want.drive, result.drive);
                    end
                    if (result.suppressed !== want.suppressed)
                    begin
                        mismatches++;
                        $display("%0t: suppress code mismatch: expected %0d, actual %0d",
                                 $time, want.suppressed, result.suppressed);
                    end
                end
            end

            // predict each accepted request
            if (sample_valid && sample_ready)
                expected_drives.push_back(predict_drive(sample));

            // register writes, masked to register widths
            if (cfg_we)
            begin
                case (pidpd_cfg_index_t'(cfg_index))
                    CFG_MODE_SELECT:    ctrl_mode = cfg_data[0];
                    CFG_GAIN_P:         kp = longint'($signed(cfg_data));
                    CFG_GAIN_I:         ki = longint'($signed(cfg_data));
                    CFG_GAIN_D:         kd = longint'($signed(cfg_data));
                    CFG_OUTPUT_LIMIT:   drive_lim = longint'(cfg_data[LIMIT_W-1:0]);
                    CFG_INTEGRAL_BOUND: integ_lim = longint'(cfg_data[LIMIT_W-1:0]);
                    CFG_ERROR_CEILING:  err_ceiling = longint'(cfg_data);
                    CFG_DEAD_ZONE:      err_floor = longint'(cfg_data);
                    default:            ;
                endcase
            end
        end
        fail_count <= mismatches;
        backlog <= expected_drives.size();
        checked_count <= checked;
    end

endmodule

// ===== test/testbench.sv =====
// top of the pid position/delta unit testbench: clock, reset, register setup,
// request and result pacing, watchdog and verdict
// depends on pidpd_pkg, pidpd_checker and pid_controller_position_delta_unit
`timescale 1ns / 1ps

module testbench;
    import pidpd_pkg::*;

    localparam int STALL_LIMIT     = 4000;
    localparam int DUT_LATENCY     = 2;
    localparam int SETTING_ROUNDS  = 15;
    localparam int ITEMS_PER_ROUND = 50;

    logic          clk          = 1'b0;
    logic          rst_n        = 1'b0;
    logic          cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic          sample_valid = 1'b0;
    logic          sample_ready;
    pidpd_sample_t sample       = '0;
    logic          result_valid;
    logic          result_ready = 1'b0;
    pidpd_result_t result;

    int fail_count;
    int backlog;
    int checked_count;

    int sender_idle_pct   = 29;
    int receiver_idle_pct = 61;
    int samples_sent      = 0;
    int settings_used     = 0;
    int loop_target       = 0;
    int error_spread      = 100;
    int quiet_cycles      = 0;

    pid_controller_position_delta_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    pidpd_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .sample        (sample),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .fail_count    (fail_count),
        .backlog       (backlog),
        .checked_count (checked_count)
    );

    // 20 ns clock
    always #10 clk = ~clk;

    // result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results still due",
                     $time, STALL_LIMIT, backlog);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic pidpd_cfg_t make_settings(
        input logic mode,
        input int   kp,
        input int   ki,
        input int   kd,
        input int   drive_limit,
        input int   integ_bound,
        input int   ceiling,
        input int   dead_band
    );
        pidpd_cfg_t c;
        c.mode_select    = mode;
        c.gain_p         = GAIN_W'(kp);
        c.gain_i         = GAIN_W'(ki);
        c.gain_d         = GAIN_W'(kd);
        c.output_limit   = LIMIT_W'(drive_limit);
        c.integral_bound = LIMIT_W'(integ_bound);
        c.error_ceiling  = DATA_WIDTH'(ceiling);
        c.dead_zone      = DATA_WIDTH'(dead_band);
        return c;
    endfunction

    function automatic int pick_gain();
        case ($urandom_range(5))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3, 4:    return int'($urandom_range(1024)) - 512;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic int pick_limit();
        case ($urandom_range(4))
            0:       return 0;
            1:       return 32767;
            2, 3:    return $urandom_range(2000);
            default: return $urandom_range(32767);
        endcase
    endfunction

    function automatic int extreme_value();
        case ($urandom_range(2))
            0:       return -32768;
            1:       return 32767;
            default: return 0;
        endcase
    endfunction

    // hold until every predicted result has come back
    task automatic wait_quiet();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input pidpd_cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    // unused upper data bits are random to exercise masking
    task automatic apply_settings(input pidpd_cfg_t c);
        wait_quiet();
        write_reg(CFG_MODE_SELECT, {15'($urandom), c.mode_select});
        write_reg(CFG_GAIN_P, c.gain_p);
        write_reg(CFG_GAIN_I, c.gain_i);
        write_reg(CFG_GAIN_D, c.gain_d);
        write_reg(CFG_OUTPUT_LIMIT, {1'($urandom), c.output_limit});
        write_reg(CFG_INTEGRAL_BOUND, {1'($urandom), c.integral_bound});
        write_reg(CFG_ERROR_CEILING, c.error_ceiling);
        write_reg(CFG_DEAD_ZONE, c.dead_zone);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // one request, with random idle cycles ahead of it
    task automatic send_sample(input int meas, input int target);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample.measured <= DATA_WIDTH'(meas);
        sample.setpoint <= DATA_WIDTH'(target);
        @(posedge clk);
        while (!(sample_valid && sample_ready))
            @(posedge clk);
        samples_sent++;
    endtask

    // mostly a loop tracking a held target, with steps, noise and extremes
    task automatic send_random_sample();
        int pick;
        int target;
        int meas;
        pick = $urandom_range(9);
        if (pick >= 7)
            loop_target = int'($urandom_range(65535)) - 32768;
        target = loop_target;
        meas = target - (int'($urandom_range(2 * error_spread)) - error_spread);
        if (pick == 5 || pick == 6)
        begin
            target = int'($urandom_range(65535)) - 32768;
            meas = int'($urandom_range(65535)) - 32768;
        end
        else if (pick == 9)
        begin
            target = extreme_value();
            meas = extreme_value();
        end
        if (meas > 32767)
            meas = 32767;
        if (meas < -32768)
            meas = -32768;
        send_sample(meas, target);
    endtask

    function automatic pidpd_cfg_t random_settings();
        int ceiling;
        int dead_band;
        case ($urandom_range(5))
            0, 1, 2: ceiling = 0;
            3:       ceiling = $urandom_range(5000);
            4:       ceiling = 65535;
            default: ceiling = $urandom_range(65535);
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: dead_band = 0;
            6, 7, 8:          dead_band = $urandom_range(50);
            default:          dead_band = $urandom_range(65535);
        endcase
        return make_settings(1'($urandom), pick_gain(), pick_gain(), pick_gain(),
                             pick_limit(), pick_limit(), ceiling, dead_band);
    endfunction

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // extreme gains and inputs, positional
        apply_settings(make_settings(MODE_POSITIONAL, 32767, -32768, 32767, 32767, 32767, 0, 0));
        send_sample(-32768, 32767);
        send_sample(32767, -32768);
        send_sample(0, 0);
        send_sample(16'h5555, -21846);
        send_sample(-21846, 16'h5555);
        send_sample(0, 1);
        send_sample(1, 0);

        // half gains for rounding, ceiling and dead zone boundaries
        apply_settings(make_settings(MODE_POSITIONAL, 128, 128, -128, 1000, 300, 100, 10));
        send_sample(0, 200);
        send_sample(0, 5);
        send_sample(0, -5);
        send_sample(0, 50);
        send_sample(0, -51);
        send_sample(0, 10);
        send_sample(0, 100);
        send_sample(0, -101);

        // ceiling below dead zone: every sample suppressed, ceiling first
        apply_settings(make_settings(MODE_INCREMENTAL, 256, 256, 256, 0, 0, 100, 200));
        send_sample(0, 150);
        send_sample(0, 300);
        send_sample(0, 50);

        // incremental ramp and full-scale swings
        apply_settings(make_settings(MODE_INCREMENTAL, 256, 64, 512, 32767, 32767, 0, 0));
        send_sample(0, 1000);
        send_sample(0, 2000);
        send_sample(0, -3000);
        send_sample(32767, -32768);
        send_sample(-32768, 32767);

        // random settings, three pacing phases
        for (int setting_idx = 0; setting_idx < SETTING_ROUNDS; setting_idx++)
        begin
            if (setting_idx < SETTING_ROUNDS / 3)
            begin
                sender_idle_pct = 29;
                receiver_idle_pct = 61;
            end
            else if (setting_idx < 2 * SETTING_ROUNDS / 3)
            begin
                sender_idle_pct = 61;
                receiver_idle_pct = 29;
            end
            else
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            apply_settings(random_settings());
            loop_target = int'($urandom_range(65535)) - 32768;
            case ($urandom_range(2))
                0:       error_spread = 8;
                1:       error_spread = 200;
                default: error_spread = 3000;
            endcase
            repeat (ITEMS_PER_ROUND)
                send_random_sample();
        end

        wait_quiet();
        repeat (2 * DUT_LATENCY) @(posedge clk);
        $display("%0d requests under %0d register settings, %0d results checked",
                 samples_sent, settings_used, checked_count);
        $display("covered both modes, ceiling and dead-zone suppression, extreme gains/limits");
        if (fail_count == 0 && backlog == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
